// ----- rtl/windowed_wildcard_pattern_search_assert.svh -----
// assertion macros used by the checker of the search block
`ifndef WINDOWED_WILDCARD_PATTERN_SEARCH_ASSERT_SVH
`define WINDOWED_WILDCARD_PATTERN_SEARCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define WWPS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define WWPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/wwps_pkg.sv -----
package wwps_pkg;

	localparam int BYTE_W      = 8;
	localparam int PAT_IDX_W   = 6;
	localparam int PAT_LEN_W   = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 25;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 8;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WC_EN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WC_VAL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 3'd4;

	localparam logic [PAT_LEN_W-1:0] PAT_LEN_RESET = 7'd1;
	localparam logic [31:0]          WIN_END_RESET = 32'h0100_0000;

	typedef struct packed {
		logic              shift;
		logic              adv;
		logic              wc_en;
		logic [BYTE_W-1:0] wc_val;
	} cell_ctrl_t;

endpackage

// ----- rtl/wwps_cell.sv -----
module wwps_cell
	import wwps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              load,
	input  logic [BYTE_W-1:0] load_byte,
	input  logic [BYTE_W-1:0] prev_byte,
	input  logic [BYTE_W-1:0] aligned_byte,
	input  logic              active,
	output logic [BYTE_W-1:0] win_byte,
	output logic              eq_s2
);

	logic [BYTE_W-1:0] win_q;
	logic [BYTE_W-1:0] pat_q;
	logic              hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q <= prev_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pat_q <= load_byte;
		end
	end

	// unused positions and wildcard bytes always agree
	assign hit = !active || (ctrl.wc_en && (pat_q == ctrl.wc_val)) || (pat_q == aligned_byte);

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			eq_s2 <= hit;
		end
	end

	assign win_byte = win_q;

endmodule

// ----- rtl/windowed_wildcard_pattern_search.sv -----
// Searches a streamed byte image for a stored pattern of up to MAX_PATTERN bytes that lies
// wholly inside the offset window [window_start, window_end). Requests with s_tuser = 0 load
// one pattern byte; requests with s_tuser = 1 carry image bytes from offset 0, and the one
// with s_tlast set returns found and range_error through the s1 and s2 stages and the output
// register. The block takes one request per cycle while not stalled: each image byte shifts
// through a row of MAX_PATTERN cells, every cell compares its aligned byte with its pattern
// byte and registers the result, and the registered match bits are then reduced. Requests stall
// only while an unread result sits in the output register and m_tready is low. Configuration
// writes are taken at any time the block is idle and need no clearing pass after reset.
module windowed_wildcard_pattern_search
	import wwps_pkg::*;
#(
	parameter int MAX_PATTERN  = 64,
	parameter int OFFSET_WIDTH = 25
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_W-1:0]    s_tdata,   // pattern_index [5:0], data_byte [13:6], zero
	input  logic                    s_tuser,   // func
	input  logic                    s_tlast,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_W-1:0]    m_tdata,   // found [0], range_error [1], zero
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [OFFSET_WIDTH-1:0] cfg_data
);

	localparam int SHW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int OW  = OFFSET_WIDTH;

	logic [PAT_LEN_W-1:0] pat_len_q;
	logic                 wc_en_q;
	logic [BYTE_W-1:0]    wc_val_q;
	logic [OW-1:0]        win_start_q;
	logic [OW-1:0]        win_end_q;
	logic [OW-1:0]        cfg_ofs;

	logic [PAT_IDX_W-1:0] pat_idx;
	logic [BYTE_W-1:0]    in_byte;
	logic                 en;
	logic                 acc;
	logic                 data_acc;
	logic                 load_acc;

	logic [OW-1:0]        pos_q;
	logic                 pos_max;
	logic [OW:0]          pos_p1;
	logic [OW:0]          len_ext;
	logic [OW:0]          start_len;
	logic                 len_ok;
	logic                 pos_ok;
	logic                 range_err;

	logic                 valid_s1, last_s1, ok_s1, err_s1;
	logic                 valid_s2, last_s2, ok_s2, err_s2;
	logic                 found_q;
	logic                 match;
	logic                 out_valid_q;
	logic                 out_found_q;
	logic                 out_err_q;

	logic [BYTE_W-1:0]            win_byte [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]       eq_s2;
	logic [MAX_PATTERN-1:0]       active;
	logic [MAX_PATTERN*BYTE_W-1:0] win_rev;
	logic [MAX_PATTERN*BYTE_W-1:0] aligned;
	logic [SHW-1:0]               sh_amt;
	cell_ctrl_t                   ctrl;

	// configuration registers
	assign cfg_ofs = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q   <= PAT_LEN_RESET;
			wc_en_q     <= 1'b0;
			wc_val_q    <= '0;
			win_start_q <= '0;
			win_end_q   <= WIN_END_RESET[OW-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LEN:   pat_len_q   <= cfg_data[PAT_LEN_W-1:0];
				REG_WC_EN:     wc_en_q     <= cfg_data[0];
				REG_WC_VAL:    wc_val_q    <= cfg_data[BYTE_W-1:0];
				REG_WIN_START: win_start_q <= cfg_ofs;
				REG_WIN_END:   win_end_q   <= cfg_ofs;
				default: ;
			endcase
		end
	end

	// request side
	assign pat_idx  = s_tdata[PAT_IDX_W-1:0];
	assign in_byte  = s_tdata[PAT_IDX_W +: BYTE_W];
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && en;
	assign data_acc = acc && (s_tuser == FUNC_DATA);
	assign load_acc = acc && (s_tuser == FUNC_LOAD);

	// position checks for the byte being accepted
	assign pos_max   = &pos_q;
	assign pos_p1    = {1'b0, pos_q} + (OW+1)'(1);
	assign len_ext   = (OW+1)'(pat_len_q);
	assign start_len = {1'b0, win_start_q} + len_ext;
	assign len_ok    = (pat_len_q != '0) && (32'(pat_len_q) <= 32'(MAX_PATTERN));
	assign pos_ok    = len_ok && !pos_max && (pos_p1 >= start_len)
		&& (pos_p1 <= {1'b0, win_end_q});
	assign range_err = (win_start_q > win_end_q) || ({1'b0, win_end_q} > pos_p1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (data_acc) begin
			if (s_tlast) begin
				pos_q <= '0;
			end else if (!pos_max) begin
				pos_q <= pos_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= data_acc;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= s_tlast;
			ok_s1   <= pos_ok;
			err_s1  <= range_err;
			last_s2 <= last_s1;
			ok_s2   <= ok_s1;
			err_s2  <= err_s1;
		end
	end

	// align the most recent pattern_length window bytes with pattern positions
	assign sh_amt = SHW'(32'(MAX_PATTERN) - 32'(pat_len_q));

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_rev[i*BYTE_W +: BYTE_W] = win_byte[MAX_PATTERN-1-i];
			active[i] = 32'(i) < 32'(pat_len_q);
		end
	end

	assign aligned = win_rev >> {sh_amt, 3'b000};

	assign ctrl.shift  = data_acc;
	assign ctrl.adv    = en;
	assign ctrl.wc_en  = wc_en_q;
	assign ctrl.wc_val = wc_val_q;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [BYTE_W-1:0] prev;
		logic              load;

		if (k == 0) begin : g_head
			assign prev = in_byte;
		end else begin : g_body
			assign prev = win_byte[k-1];
		end

		assign load = load_acc && (32'(pat_idx) == 32'(k));

		wwps_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.load         (load),
			.load_byte    (in_byte),
			.prev_byte    (prev),
			.aligned_byte (aligned[k*BYTE_W +: BYTE_W]),
			.active       (active[k]),
			.win_byte     (win_byte[k]),
			.eq_s2        (eq_s2[k])
		);
	end

	// sticky match flag and result register
	assign match = ok_s2 && (&eq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (en && valid_s2) begin
			found_q <= last_s2 ? 1'b0 : (found_q || match);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2 && last_s2) begin
			out_found_q <= !err_s2 && (found_q || match);
			out_err_q   <= err_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, out_err_q, out_found_q};

endmodule

// ----- rtl/wwps_checker.sv -----
`include "windowed_wildcard_pattern_search_assert.svh"

module wwps_checker
	import wwps_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled result holds
	`WWPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a range error always clears found
	`WWPS_ASSERT_SAME(a_err_clears_found, m_tvalid && m_tdata[1], !m_tdata[0])

	// requests only wait on a full, stalled result register
	`WWPS_ASSERT_SAME(a_ready_when_free, !m_tvalid || m_tready, s_tready)

	// padding bits stay zero
	`WWPS_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:2] == '0)

endmodule

bind windowed_wildcard_pattern_search wwps_checker u_wwps_checker (.*);

// ----- dv/tb_windowed_wildcard_pattern_search.sv -----
`timescale 1ns / 1ps

module tb_windowed_wildcard_pattern_search;
	import wwps_pkg::*;

	localparam int PAT_DEPTH = 64;
	localparam longint unsigned POS_MAX = 64'h1FF_FFFF;
	localparam int IDLE_LIMIT = 5000;
	localparam int ITEM_TARGET = 1350;
	localparam int IMAGE_TARGET = 40;

	typedef struct packed {
		logic found;
		logic range_error;
	} search_verdict_t;

	typedef bit [7:0] byte_q_t[$];

	class search_scoreboard;
		bit [7:0] pattern_mem[PAT_DEPTH];
		bit [7:0] recent[PAT_DEPTH];
		longint unsigned offset;
		bit hit_seen;
		int unsigned pat_len;
		bit wc_on;
		bit [7:0] wc_byte;
		longint unsigned win_start;
		longint unsigned win_end;
		search_verdict_t expected_verdicts[$];
		int mismatches;
		int images_closed;

		function new();
			pat_len = 32'(PAT_LEN_RESET);
			wc_on = 1'b0;
			wc_byte = 8'h00;
			win_start = 0;
			win_end = 64'(WIN_END_RESET);
			offset = 0;
			hit_seen = 1'b0;
			mismatches = 0;
			images_closed = 0;
			foreach (recent[i]) recent[i] = 8'h00;
			foreach (pattern_mem[i]) pattern_mem[i] = 8'h00;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_PAT_LEN: pat_len = 32'(val[PAT_LEN_W-1:0]);
				REG_WC_EN: wc_on = val[0];
				REG_WC_VAL: wc_byte = val[BYTE_W-1:0];
				REG_WIN_START: win_start = 64'(val);
				REG_WIN_END: win_end = 64'(val);
				default: ;
			endcase
		endfunction

		function bit window_matches(longint unsigned at);
			longint unsigned len;
			len = 64'(pat_len);
			if (len == 0 || len > PAT_DEPTH) return 1'b0;
			if (at + 1 < len) return 1'b0;
			if (at + 1 - len < win_start) return 1'b0;
			if (at + 1 > win_end) return 1'b0;
			for (longint unsigned k = 0; k < len; k++) begin
				if (wc_on && pattern_mem[k] == wc_byte) continue;
				if (pattern_mem[k] != recent[len - 1 - k]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void take_request(logic func, logic [PAT_IDX_W-1:0] idx, logic [7:0] data_b,
				logic last);
			longint unsigned at;
			bit err;
			search_verdict_t v;
			if (func == FUNC_LOAD) begin
				pattern_mem[idx] = data_b;
				return;
			end
			for (int i = PAT_DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
			recent[0] = data_b;
			at = offset;
			if (at != POS_MAX && window_matches(at)) hit_seen = 1'b1;
			if (offset < POS_MAX) offset++;
			if (!last) return;
			err = (win_start > win_end) || (win_end > at + 1);
			v.found = !err && hit_seen;
			v.range_error = err;
			expected_verdicts.push_back(v);
			images_closed++;
			offset = 0;
			hit_seen = 1'b0;
			foreach (recent[i]) recent[i] = 8'h00;
		endfunction

		task report(string what);
			mismatches++;
			$display("%0t ns: %s", $time, what);
		endtask

		task compare_result(logic found, logic range_error);
			search_verdict_t v;
			if (expected_verdicts.size() == 0) begin
				report("result with no image closed");
				return;
			end
			v = expected_verdicts.pop_front();
			if (found !== v.found)
				report($sformatf("found got %b want %b", found, v.found));
			if (range_error !== v.range_error)
				report($sformatf("range_error got %b want %b", range_error, v.range_error));
		endtask

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	search_scoreboard sb = new();

	int cur_len;
	int cur_start;
	int cur_end;
	bit cur_wen;
	bit [7:0] cur_wval;
	bit [7:0] pattern_bytes[PAT_DEPTH];
	bit [7:0] alphabet[4];
	bit use_alpha;
	int burst_left;
	int items_sent;
	int idle_cycles;
	int rx_left;
	int rx_mode;

	windowed_wildcard_pattern_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: ready follows its own pattern of modes
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(5, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (rx_left % 16 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.compare_result(m_tdata[0], m_tdata[1]);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push(logic func, logic [PAT_IDX_W-1:0] idx, logic [7:0] data_b, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {2'b00, data_b, idx};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.take_request(func, idx, data_b, last);
		burst_left--;
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_settings(int len, bit wen, bit [7:0] wval, int start, int stop);
		wait_idle();
		write_reg(REG_PAT_LEN, CFG_DATA_W'(len));
		write_reg(REG_WC_EN, CFG_DATA_W'(wen));
		write_reg(REG_WC_VAL, CFG_DATA_W'(wval));
		write_reg(REG_WIN_START, CFG_DATA_W'(start));
		write_reg(REG_WIN_END, CFG_DATA_W'(stop));
		cfg_we <= 1'b0;
		cur_len = len;
		cur_wen = wen;
		cur_wval = wval;
		cur_start = start;
		cur_end = stop;
	endtask

	task automatic send_image(byte_q_t img, bit noisy);
		int idx;
		bit [7:0] b;
		foreach (img[i]) begin
			if (noisy && $urandom_range(0, 29) == 0) begin
				idx = $urandom_range(0, PAT_DEPTH - 1);
				b = 8'($urandom_range(0, 255));
				push(FUNC_LOAD, PAT_IDX_W'(idx), b, 1'($urandom_range(0, 1)));
				pattern_bytes[idx] = b;
			end
			push(FUNC_DATA, PAT_IDX_W'($urandom_range(0, PAT_DEPTH - 1)), img[i],
				i == img.size() - 1);
		end
	endtask

	initial begin
		byte_q_t img;
		int n;
		int o;
		int lo;
		int hi;
		int span;
		int kind;
		int images;
		bit first;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		items_sent = 0;
		idle_cycles = 0;
		rx_left = 0;
		rx_mode = 0;
		cur_len = 32'(PAT_LEN_RESET);
		cur_wen = 1'b0;
		cur_wval = 8'h00;
		cur_start = 0;
		cur_end = WIN_END_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window end far past any image
		push(FUNC_LOAD, PAT_IDX_W'(0), 8'hFF, 1'b0);
		push(FUNC_LOAD, PAT_IDX_W'(PAT_DEPTH - 1), 8'h00, 1'b0);
		push(FUNC_LOAD, PAT_IDX_W'(5), 8'h3C, 1'b1);
		img = {8'h11, 8'hFF, 8'h22};
		send_image(img, 1'b0);

		// wildcard in the first pattern byte
		apply_settings(2, 1'b1, 8'hAA, 0, 4);
		push(FUNC_LOAD, PAT_IDX_W'(0), 8'hAA, 1'b0);
		push(FUNC_LOAD, PAT_IDX_W'(1), 8'h00, 1'b0);
		img = {8'h12, 8'h00, 8'hFF, 8'h00};
		send_image(img, 1'b0);

		// match that begins before the window start
		apply_settings(2, 1'b0, 8'h00, 2, 4);
		img = {8'hAA, 8'h00, 8'h11, 8'h22};
		send_image(img, 1'b0);

		// empty pattern
		apply_settings(0, 1'b0, 8'h00, 0, 2);
		img = {8'h00, 8'h00};
		send_image(img, 1'b0);

		// pattern longer than the store
		apply_settings(100, 1'b0, 8'hFF, 0, 3);
		img = {8'hAA, 8'h00, 8'hAA};
		send_image(img, 1'b0);

		// start past end
		apply_settings(1, 1'b0, 8'h00, 3, 1);
		img = {8'hAA, 8'hAA};
		send_image(img, 1'b0);

		// window at offset 1 << 24, the middle of the offset range
		apply_settings(1, 1'b0, 8'h00, 1 << 24, 1 << 24);
		img = {8'hAA};
		send_image(img, 1'b0);

		first = 1'b1;
		while (items_sent < ITEM_TARGET || sb.images_closed < IMAGE_TARGET) begin
			use_alpha = $urandom_range(0, 9) < 7;
			foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));

			if (first || $urandom_range(0, 9) < 7) begin
				kind = $urandom_range(0, 99);
				if (kind < 70) n = $urandom_range(1, 6);
				else if (kind < 85) n = $urandom_range(7, PAT_DEPTH);
				else if (kind < 90) n = 0;
				else if (kind < 95) n = PAT_DEPTH;
				else n = $urandom_range(PAT_DEPTH + 1, 127);
				cur_len = n;
				for (int k = 0; k < PAT_DEPTH; k++)
					pattern_bytes[k] = use_alpha ? alphabet[$urandom_range(0, 3)]
						: 8'($urandom_range(0, 255));
				cur_wen = 1'($urandom_range(0, 1));
				if (n >= 1 && n <= PAT_DEPTH && $urandom_range(0, 2) != 0)
					cur_wval = pattern_bytes[$urandom_range(0, n - 1)];
				else
					cur_wval = 8'($urandom_range(0, 255));
				span = (n >= 1 && n <= PAT_DEPTH) ? n : $urandom_range(0, 10);
				kind = $urandom_range(0, 99);
				if (kind < 65) begin
					cur_start = $urandom_range(0, 8);
					cur_end = cur_start + span + $urandom_range(0, 20);
				end else if (kind < 75) begin
					cur_start = $urandom_range(1, 20);
					cur_end = $urandom_range(0, cur_start - 1);
				end else if (kind < 85) begin
					cur_start = $urandom & 32'h00FF_FFFF;
					cur_end = $urandom & 32'h00FF_FFFF;
				end else if (kind < 90) begin
					cur_start = $urandom_range(0, 1) ? (1 << 24) : 0;
					cur_end = 1 << 24;
				end else if (kind < 95) begin
					cur_start = 0;
					cur_end = 0;
				end else begin
					cur_start = 1 << 24;
					cur_end = 1 << 24;
				end
				apply_settings(cur_len, cur_wen, cur_wval, cur_start, cur_end);
				first = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				wait_idle();
			end

			for (int k = 0; k < cur_len && k < PAT_DEPTH; k++)
				push(FUNC_LOAD, PAT_IDX_W'(k), pattern_bytes[k], $urandom_range(0, 7) == 0);

			images = $urandom_range(2, 6);
			repeat (images) begin
				if (cur_end <= 150) begin
					if ($urandom_range(0, 3) != 0) n = cur_end + $urandom_range(0, 5);
					else n = $urandom_range(1, cur_end + 5);
				end else begin
					n = $urandom_range(1, 40);
				end
				if (n < 1) n = 1;
				img = {};
				for (int i = 0; i < n; i++)
					img.push_back(use_alpha ? alphabet[$urandom_range(0, 3)]
						: 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 3) != 0 && cur_len >= 1 && cur_len <= PAT_DEPTH
						&& n >= cur_len) begin
					lo = cur_start;
					hi = ((cur_end < n) ? cur_end : n) - cur_len;
					if (lo > hi || $urandom_range(0, 4) == 0) begin
						lo = 0;
						hi = n - cur_len;
					end
					o = $urandom_range(hi, lo);
					for (int k = 0; k < cur_len; k++)
						img[o + k] = (cur_wen && pattern_bytes[k] == cur_wval)
							? 8'($urandom_range(0, 255)) : pattern_bytes[k];
				end
				send_image(img, 1'b1);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
